>>> rtl/pcv_pkg.sv
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared constants and types of the primitive cull and viewport stage.
// ----------------------------------------------------------------------------
package pcv_pkg;

	// Fraction bits of every Q format in the block.
	localparam int FRAC_BITS = 16;
	// Dividend width: a 32-bit value shifted up by the fraction bits.
	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);

	// Slot counter limit, min(MAX_PRIMITIVES - 1, 4095).
	localparam int MAX_PRIMITIVES = 4096;
	localparam int SLOT_LIMIT = (MAX_PRIMITIVES - 1) > 4095 ? 4095 : (MAX_PRIMITIVES - 1);

	localparam logic [5:0] OUTCODE_ALL = 6'h3F;
	localparam logic [NUM_W-1:0] PSIZE_NUM = NUM_W'(15) << (2 * FRAC_BITS);

	// Configuration register indexes.
	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_SCALE_X  = 3'd1;
	localparam logic [2:0] CFG_OFFSET_X = 3'd2;
	localparam logic [2:0] CFG_SCALE_Y  = 3'd3;
	localparam logic [2:0] CFG_OFFSET_Y = 3'd4;
	localparam logic [2:0] CFG_SCALE_Z  = 3'd5;
	localparam logic [2:0] CFG_OFFSET_Z = 3'd6;
	localparam logic [2:0] CFG_GUARD    = 3'd7;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [31:0]      den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/pcv_div.sv
// ----------------------------------------------------------------------------
// pcv_div
// Restoring divider, one quotient bit per cycle, result truncated toward
// zero and saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module pcv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pcv_pkg::div_req_t req,
	output pcv_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        fin_q;
	logic [pcv_pkg::CNT_W-1:0]   cnt_q;
	logic [pcv_pkg::NUM_W-1:0]   quo_q;
	logic [31:0]                 rem_q;
	logic [31:0]                 dm_q;
	logic                        neg_q;
	logic                        num_pos_q;
	logic                        num_neg_q;
	logic                        den_zero_q;
	logic                        done_q;
	logic signed [31:0]          res_q;

	logic [pcv_pkg::NUM_W-1:0]   num_mag;
	logic [31:0]                 den_mag;
	logic [32:0]                 trial;
	logic                        fits;
	logic [32:0]                 trial_sub;
	logic signed [31:0]          fin_val;

	assign num_mag = req.num[pcv_pkg::NUM_W-1] ? pcv_pkg::NUM_W'(-req.num) : req.num;
	assign den_mag = req.den[31] ? 32'(-req.den) : req.den;
	assign trial     = {rem_q, quo_q[pcv_pkg::NUM_W-1]};
	assign fits      = trial >= {1'b0, dm_q};
	assign trial_sub = trial - {1'b0, dm_q};

	always_comb begin
		if (den_zero_q) begin
			if (num_pos_q) fin_val = 32'sh7FFF_FFFF;
			else if (num_neg_q) fin_val = 32'sh8000_0000;
			else fin_val = '0;
		end else if (!neg_q) begin
			if (quo_q > pcv_pkg::NUM_W'(32'h7FFF_FFFF)) fin_val = 32'sh7FFF_FFFF;
			else fin_val = quo_q[31:0];
		end else begin
			if (quo_q > pcv_pkg::NUM_W'(32'h8000_0000)) fin_val = 32'sh8000_0000;
			else fin_val = 32'(-quo_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q && !fin_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == pcv_pkg::CNT_W'(pcv_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q && !fin_q) begin
			quo_q      <= num_mag;
			rem_q      <= '0;
			dm_q       <= den_mag;
			neg_q      <= req.num[pcv_pkg::NUM_W-1] ^ req.den[31];
			num_pos_q  <= !req.num[pcv_pkg::NUM_W-1] && (req.num != '0);
			num_neg_q  <= req.num[pcv_pkg::NUM_W-1];
			den_zero_q <= req.den == '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[31:0] : trial[31:0];
			quo_q <= {quo_q[pcv_pkg::NUM_W-2:0], fits};
		end
		if (fin_q) res_q <= fin_val;
	end

	assign rsp.done = done_q;
	assign rsp.quo  = res_q;

endmodule

>>> rtl/primitive_cull_viewport_stage_unit.sv
// ----------------------------------------------------------------------------
// primitive_cull_viewport_stage_unit
// Divides clip-space vertices by w, culls triangles against the clip planes
// and guard band and points against the clip planes, applies the viewport
// transform, and culls back-facing and zero-area triangles.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                       Transfer when
//  s_axis   in   tdata: pos_x,y,z,w, tex_u,v; tuser: batch     tvalid & tready
//  m_axis   out  tdata: screen_x,y,z, out_u,v,w, slot_index;   tvalid & tready
//                tlast: last_of_primitive
//  cfg      in   cfg_index, cfg_data                           cfg_valid & cfg_ready
//
//  One vertex is taken at a time. The shared restoring divider makes three
//  quotients per vertex (four in point mode). The shared 33x33 multiplier
//  then does the viewport terms and the two area products. Results leave
//  through one output register, so a stalled consumer holds the emit
//  sequence but a new vertex is taken once all are loaded.
//  Reset clears control state and loads the register defaults.
//
module primitive_cull_viewport_stage_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] pos_w,
	// [159:128] tex_u, [191:160] tex_v
	input  logic [191:0] s_axis_tdata,
	// [0] batch_start
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] screen_x, [63:32] screen_y, [95:64] screen_z, [127:96] out_u,
	// [159:128] out_v, [191:160] out_w, [203:192] slot_index, [207:204] zero
	output logic [207:0] m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVGO = 4'd1;
	localparam logic [3:0] ST_DIVWT = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ACC   = 4'd5;
	localparam logic [3:0] ST_AREA1 = 4'd6;
	localparam logic [3:0] ST_AREA2 = 4'd7;
	localparam logic [3:0] ST_CMP   = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0] state_q;

	// Configuration registers.
	logic               mode_q;
	logic signed [31:0] vp_q [6];
	logic [30:0]        guard_q;

	// Grouping state.
	logic [1:0]  phase_q;
	logic [5:0]  and_q;
	logic [5:0]  or_q;
	logic [11:0] count_q;
	logic [11:0] slot_q;

	// Current vertex.
	logic signed [31:0] px_q, py_q, pz_q, pw_q, pu_q, pv_q;
	logic               point_q;
	logic signed [31:0] ndc_q [3];
	logic signed [31:0] psize_q;
	logic [1:0]         dsel_q;

	logic signed [31:0] held_ndc_q  [6];
	logic signed [31:0] held_attr_q [6];
	logic signed [31:0] scr_q [3][3];

	logic [1:0] vtx_q;
	logic [1:0] axis_q;
	logic [1:0] emit_q;

	logic signed [65:0] prod_q;
	logic signed [65:0] p1_q;

	logic         out_valid_q;
	logic [207:0] out_data_q;
	logic         out_last_q;

	pcv_pkg::div_req_t div_req;
	pcv_pkg::div_rsp_t div_rsp;

	pcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic in_xfer;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;

	// Divider numerator: the selected coordinate times 2^FRAC_BITS, or the
	// point size constant.
	logic signed [31:0] div_src;
	always_comb begin
		case (dsel_q)
			2'd0:    div_src = px_q;
			2'd1:    div_src = py_q;
			default: div_src = pz_q;
		endcase
		div_req.start = state_q == ST_DIVGO;
		div_req.den   = pw_q;
		if (dsel_q == 2'd3) div_req.num = pcv_pkg::PSIZE_NUM;
		else div_req.num = {div_src, {pcv_pkg::FRAC_BITS{1'b0}}};
	end

	// Clip-space outcodes against -w and +w.
	logic signed [32:0] w33, nw33;
	logic [5:0] clip_code;
	assign w33  = 33'(pw_q);
	assign nw33 = -w33;
	always_comb begin
		clip_code[0] = 33'(px_q) < nw33;
		clip_code[1] = 33'(px_q) > w33;
		clip_code[2] = 33'(py_q) < nw33;
		clip_code[3] = 33'(py_q) > w33;
		clip_code[4] = 33'(pz_q) < nw33;
		clip_code[5] = 33'(pz_q) > w33;
	end

	// Guard band codes on NDC.
	logic signed [32:0] g33, ng33;
	logic [5:0] guard_code;
	assign g33  = {2'b00, guard_q};
	assign ng33 = -g33;
	always_comb begin
		guard_code[0] = 33'(ndc_q[0]) < ng33;
		guard_code[1] = 33'(ndc_q[0]) > g33;
		guard_code[2] = 33'(ndc_q[1]) < ng33;
		guard_code[3] = 33'(ndc_q[1]) > g33;
		guard_code[4] = 33'(ndc_q[2]) < ng33;
		guard_code[5] = 33'(ndc_q[2]) > g33;
	end

	logic [5:0] and_new, or_new;
	assign and_new = and_q & clip_code;
	assign or_new  = or_q | guard_code;

	// Shared multiplier operands.
	logic [2:0]         held_idx;
	logic [2:0]         vp_idx;
	logic signed [31:0] ndc_sel;
	logic signed [32:0] dx1, dy1, dx2, dy2;
	logic signed [32:0] mul_a, mul_b;
	assign held_idx = vtx_q[0] ? 3'(axis_q) + 3'd3 : 3'(axis_q);
	assign vp_idx   = {axis_q, 1'b0};
	assign ndc_sel  = (vtx_q == 2'd2) ? ndc_q[axis_q] : held_ndc_q[held_idx];
	assign dx1 = 33'(scr_q[1][0]) - 33'(scr_q[0][0]);
	assign dy1 = 33'(scr_q[1][1]) - 33'(scr_q[0][1]);
	assign dx2 = 33'(scr_q[2][0]) - 33'(scr_q[0][0]);
	assign dy2 = 33'(scr_q[2][1]) - 33'(scr_q[0][1]);
	always_comb begin
		if (state_q == ST_AREA1) begin
			mul_a = dx1;
			mul_b = dy2;
		end else if (state_q == ST_AREA2) begin
			mul_a = dx2;
			mul_b = dy1;
		end else begin
			mul_a = 33'(ndc_sel);
			mul_b = 33'(vp_q[vp_idx]);
		end
	end

	// Viewport: floor(prod / 2^FRAC_BITS) + offset, saturated.
	logic signed [31:0] vp_off;
	logic signed [66-pcv_pkg::FRAC_BITS:0] vp_sum;
	logic signed [31:0] vp_res;
	assign vp_off = vp_q[vp_idx + 3'd1];
	assign vp_sum = (66-pcv_pkg::FRAC_BITS+1)'($signed(prod_q[65:pcv_pkg::FRAC_BITS]))
		+ (66-pcv_pkg::FRAC_BITS+1)'(vp_off);
	always_comb begin
		if (vp_sum > (66-pcv_pkg::FRAC_BITS+1)'(32'sh7FFF_FFFF)) vp_res = 32'sh7FFF_FFFF;
		else if (vp_sum < (66-pcv_pkg::FRAC_BITS+1)'(32'sh8000_0000)) vp_res = 32'sh8000_0000;
		else vp_res = vp_sum[31:0];
	end

	// Exact area sign.
	logic signed [66:0] area;
	logic area_pos;
	assign area     = 67'(p1_q) - 67'(prod_q);
	assign area_pos = !area[66] && (area != '0);

	// Output item for the vertex being emitted.
	logic signed [31:0] e_u, e_v, e_w;
	logic [2:0] attr_idx;
	assign attr_idx = emit_q[0] ? 3'd3 : 3'd0;
	always_comb begin
		if (emit_q == 2'd2) begin
			e_u = point_q ? psize_q : pu_q;
			e_v = point_q ? 32'sd0 : pv_q;
			e_w = pw_q;
		end else begin
			e_u = held_attr_q[attr_idx];
			e_v = held_attr_q[attr_idx + 3'd1];
			e_w = held_attr_q[attr_idx + 3'd2];
		end
	end

	function automatic logic [2:0] attr_idx_w(input logic odd);
		return odd ? 3'd3 : 3'd0;
	endfunction

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			vp_q[0] <= 32'sd65536;
			vp_q[1] <= '0;
			vp_q[2] <= 32'sd65536;
			vp_q[3] <= '0;
			vp_q[4] <= 32'sd65536;
			vp_q[5] <= '0;
			guard_q <= 31'd524288;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcv_pkg::CFG_MODE:     mode_q  <= cfg_data[0];
				pcv_pkg::CFG_SCALE_X:  vp_q[0] <= cfg_data;
				pcv_pkg::CFG_OFFSET_X: vp_q[1] <= cfg_data;
				pcv_pkg::CFG_SCALE_Y:  vp_q[2] <= cfg_data;
				pcv_pkg::CFG_OFFSET_Y: vp_q[3] <= cfg_data;
				pcv_pkg::CFG_SCALE_Z:  vp_q[4] <= cfg_data;
				pcv_pkg::CFG_OFFSET_Z: vp_q[5] <= cfg_data;
				pcv_pkg::CFG_GUARD:    guard_q <= cfg_data[30:0];
				default:               mode_q  <= mode_q;
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			and_q       <= pcv_pkg::OUTCODE_ALL;
			or_q        <= '0;
			count_q     <= '0;
			dsel_q      <= '0;
			vtx_q       <= '0;
			axis_q      <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register is loaded whenever it is free in the emit
			// state, and is emptied by a transfer otherwise.
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser) begin
							count_q <= '0;
							phase_q <= '0;
							and_q   <= pcv_pkg::OUTCODE_ALL;
							or_q    <= '0;
						end
						dsel_q  <= '0;
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: state_q <= ST_DIVWT;
				ST_DIVWT: begin
					if (div_rsp.done) begin
						if (dsel_q == 2'd3 || (dsel_q == 2'd2 && !point_q)) begin
							state_q <= ST_CHK;
						end else begin
							dsel_q  <= dsel_q + 2'd1;
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_CHK: begin
					axis_q <= '0;
					if (point_q) begin
						vtx_q   <= 2'd2;
						state_q <= (clip_code != '0) ? ST_IDLE : ST_MUL;
					end else if (phase_q < 2'd2) begin
						and_q   <= and_new;
						or_q    <= or_new;
						phase_q <= phase_q + 2'd1;
						state_q <= ST_IDLE;
					end else begin
						phase_q <= '0;
						and_q   <= pcv_pkg::OUTCODE_ALL;
						or_q    <= '0;
						vtx_q   <= '0;
						state_q <= (and_new != '0 || or_new != '0) ? ST_IDLE : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (axis_q == 2'd2) begin
						axis_q <= '0;
						if (vtx_q == 2'd2) begin
							if (point_q) begin
								emit_q  <= 2'd2;
								slot_q  <= count_q;
								if (count_q < 12'(pcv_pkg::SLOT_LIMIT)) count_q <= count_q + 12'd1;
								state_q <= ST_EMIT;
							end else begin
								state_q <= ST_AREA1;
							end
						end else begin
							vtx_q   <= vtx_q + 2'd1;
							state_q <= ST_MUL;
						end
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_AREA1: state_q <= ST_AREA2;
				ST_AREA2: state_q <= ST_CMP;
				ST_CMP: begin
					if (area_pos) begin
						emit_q  <= '0;
						slot_q  <= count_q;
						if (count_q < 12'(pcv_pkg::SLOT_LIMIT)) count_q <= count_q + 12'd1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (emit_q == 2'd2) state_q <= ST_IDLE;
						else emit_q <= emit_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_q    <= s_axis_tdata[31:0];
			py_q    <= s_axis_tdata[63:32];
			pz_q    <= s_axis_tdata[95:64];
			pw_q    <= s_axis_tdata[127:96];
			pu_q    <= s_axis_tdata[159:128];
			pv_q    <= s_axis_tdata[191:160];
			point_q <= mode_q;
		end
		if (state_q == ST_DIVWT && div_rsp.done) begin
			if (dsel_q == 2'd3) psize_q <= div_rsp.quo;
			else ndc_q[dsel_q] <= div_rsp.quo;
		end
		// The first two vertices of a triangle are held until the third.
		if (state_q == ST_CHK && !point_q && phase_q < 2'd2) begin
			held_ndc_q[attr_idx_w(phase_q[0])]         <= ndc_q[0];
			held_ndc_q[attr_idx_w(phase_q[0]) + 3'd1] <= ndc_q[1];
			held_ndc_q[attr_idx_w(phase_q[0]) + 3'd2] <= ndc_q[2];
			held_attr_q[attr_idx_w(phase_q[0])]        <= pu_q;
			held_attr_q[attr_idx_w(phase_q[0]) + 3'd1] <= pv_q;
			held_attr_q[attr_idx_w(phase_q[0]) + 3'd2] <= pw_q;
		end
		if (state_q == ST_MUL || state_q == ST_AREA1 || state_q == ST_AREA2) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_AREA2) p1_q <= prod_q;
		if (state_q == ST_ACC) scr_q[vtx_q][axis_q] <= vp_res;
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= {4'h0, slot_q, e_w, e_v, e_u,
				scr_q[emit_q][2], scr_q[emit_q][1], scr_q[emit_q][0]};
			out_last_q <= emit_q == 2'd2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/pcv_chk.sv
// ----------------------------------------------------------------------------
// pcv_chk
// Port-level checks of the primitive cull and viewport stage.
// ----------------------------------------------------------------------------
module pcv_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [191:0] s_axis_tdata,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [207:0] m_axis_tdata,
	input logic         m_axis_tlast,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [2:0]   cfg_index,
	input logic [31:0]  cfg_data
);

	// A vertex keeps the block busy for at least the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

	// No result is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid in reset");

	// The spare bits above slot_index stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[207:204] == 4'h0)
		else $error("padding bits set");

endmodule

bind primitive_cull_viewport_stage_unit pcv_chk u_pcv_chk (.*);
